/* hw/rtl/pubsub_membership_table_top_assert.svh */
// Assertion macros used by the checker file of this block.
`ifndef PUBSUB_MEMBERSHIP_TABLE_TOP_ASSERT_SVH
`define PUBSUB_MEMBERSHIP_TABLE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PMT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PMT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/pmt_pkg.sv */
`default_nettype none

package pmt_pkg;

    localparam int TOPIC_SLOTS_DEF = 8;
    localparam int PUB_SLOTS_DEF   = 8;
    localparam int SUB_SLOTS_DEF   = 8;
    localparam int NAME_BYTES_DEF  = 8;

    localparam int KEY_W    = 64;
    localparam int CONN_W   = 16;
    localparam int ID_W     = 32;
    localparam int STATUS_W = 2;
    localparam int ACTION_W = 3;

    localparam logic [ACTION_W-1:0] ACT_ADD        = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_REMOVE     = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_LIST_TOPIC = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_LIST_PUB   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_LIST_SUB   = 3'd4;

    localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_MISS = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_TOPIC,
        S_SLOT,
        S_EMPTY,
        S_LIST,
        S_RESP
    } t_state;

    typedef struct packed {
        logic              valid;
        logic [ID_W-1:0]   id;
        logic [CONN_W-1:0] conn;
    } t_slot;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     assigned_id;
        logic                item_valid;
        logic [CONN_W-1:0]   conn;
        logic                last;
    } t_result;

    // Address width for a store of n entries, at least one bit.
    function automatic int pmt_aw(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

    // Keeps the low nbytes bytes up to the first zero byte.
    function automatic logic [KEY_W-1:0] pmt_norm_key(input logic [KEY_W-1:0] key,
                                                      input int nbytes);
        logic [KEY_W-1:0] r;
        logic             done;
        r    = '0;
        done = 1'b0;
        for (int b = 0; b < 8; b++) begin
            if (b < nbytes && !done) begin
                if (key[8*b +: 8] == 8'd0) begin
                    done = 1'b1;
                end else begin
                    r[8*b +: 8] = key[8*b +: 8];
                end
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/pmt_core.sv */
`default_nettype none

module pmt_core #(
    parameter int TOPIC_SLOTS = pmt_pkg::TOPIC_SLOTS_DEF,
    parameter int PUB_SLOTS   = pmt_pkg::PUB_SLOTS_DEF,
    parameter int SUB_SLOTS   = pmt_pkg::SUB_SLOTS_DEF,
    parameter int NAME_BYTES  = pmt_pkg::NAME_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [pmt_pkg::ACTION_W-1:0]  i_action,
    input  logic                          i_role,
    input  logic [pmt_pkg::KEY_W-1:0]     i_topic_key,
    input  logic [pmt_pkg::CONN_W-1:0]    i_connection,
    input  logic [pmt_pkg::ID_W-1:0]      i_client_id,
    output logic                          o_push,
    output pmt_pkg::t_result              o_res,
    input  logic                          i_free
);
    import pmt_pkg::*;

    localparam int MAXN = (PUB_SLOTS > SUB_SLOTS) ? PUB_SLOTS : SUB_SLOTS;
    localparam int TAW  = pmt_aw(TOPIC_SLOTS);
    localparam int PAW  = pmt_aw(TOPIC_SLOTS * PUB_SLOTS);
    localparam int SAW  = pmt_aw(TOPIC_SLOTS * SUB_SLOTS);
    localparam int IW   = pmt_aw(TOPIC_SLOTS * MAXN);
    localparam int CPW  = $clog2(PUB_SLOTS + 1);
    localparam int CSW  = $clog2(SUB_SLOTS + 1);

    localparam logic [IW-1:0] CLR_LAST     = IW'(TOPIC_SLOTS * MAXN - 1);
    localparam logic [IW-1:0] PUB_ALL_LAST = IW'(TOPIC_SLOTS * PUB_SLOTS - 1);
    localparam logic [IW-1:0] SUB_ALL_LAST = IW'(TOPIC_SLOTS * SUB_SLOTS - 1);
    localparam logic [IW-1:0] TOP_LAST     = IW'(TOPIC_SLOTS - 1);
    localparam logic [IW-1:0] P_LAST       = IW'(PUB_SLOTS - 1);
    localparam logic [IW-1:0] S_LAST       = IW'(SUB_SLOTS - 1);

    logic [KEY_W-1:0] m_topic [TOPIC_SLOTS];
    t_slot            m_pub   [TOPIC_SLOTS * PUB_SLOTS];
    t_slot            m_sub   [TOPIC_SLOTS * SUB_SLOTS];

    logic [KEY_W-1:0] r_topic_rd;
    t_slot            r_pub_rd;
    t_slot            r_sub_rd;

    t_state              r_state, n_state;
    logic [IW-1:0]       r_idx, n_idx;
    logic                r_wait, n_wait;
    logic [IW-1:0]       r_lim, n_lim;
    logic                r_lin, n_lin;
    logic                r_role, n_role;
    logic [TAW-1:0]      r_topic, n_topic;
    logic [ACTION_W-1:0] r_action, n_action;
    logic [KEY_W-1:0]    r_key, n_key;
    logic [CONN_W-1:0]   r_conn, n_conn;
    logic [ID_W-1:0]     r_cid, n_cid;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [ID_W-1:0]     r_id, n_id;
    logic                r_have, n_have;
    logic [CONN_W-1:0]   r_pend, n_pend;
    logic [CPW-1:0]      r_pub_total, n_pub_total;
    logic [CSW-1:0]      r_sub_total, n_sub_total;
    logic [ID_W-1:0]     r_next_id, n_next_id;

    logic [KEY_W-1:0] in_key;
    logic             accept;
    logic             role_full;
    logic [TAW-1:0]   topic_ra, topic_wa;
    logic [PAW-1:0]   pub_ra;
    logic [SAW-1:0]   sub_ra;
    logic             topic_we, pub_we, sub_we;
    logic [KEY_W-1:0] topic_wd;
    t_slot            slot_wd;
    t_slot            entry;
    logic             key_hit, name_free, id_hit, at_end, step;

    assign in_key     = pmt_norm_key(i_topic_key, NAME_BYTES);
    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign role_full  = i_role ? (r_sub_total == CSW'(SUB_SLOTS))
                               : (r_pub_total == CPW'(PUB_SLOTS));

    assign topic_ra = r_idx[TAW-1:0];
    assign topic_wa = (r_state == S_CLEAR) ? r_idx[TAW-1:0] : r_topic;
    assign pub_ra   = r_lin ? PAW'(r_idx)
                            : PAW'(int'(r_topic) * PUB_SLOTS + int'(r_idx));
    assign sub_ra   = r_lin ? SAW'(r_idx)
                            : SAW'(int'(r_topic) * SUB_SLOTS + int'(r_idx));

    assign entry     = r_role ? r_sub_rd : r_pub_rd;
    assign key_hit   = (r_topic_rd == r_key);
    assign name_free = (r_topic_rd == '0);
    assign id_hit    = entry.valid && (entry.id == r_cid);
    assign at_end    = (r_idx == r_lim);
    assign step      = !r_wait;

    // Slot writes always land on the entry that is being looked at.
    always_ff @(posedge i_clk) begin
        if (topic_we) begin
            m_topic[topic_wa] <= topic_wd;
        end
        if (pub_we) begin
            m_pub[pub_ra] <= slot_wd;
        end
        if (sub_we) begin
            m_sub[sub_ra] <= slot_wd;
        end
        r_topic_rd <= m_topic[topic_ra];
        r_pub_rd   <= m_pub[pub_ra];
        r_sub_rd   <= m_sub[sub_ra];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_idx == CLR_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    unique case (i_action)
                        ACT_ADD: begin
                            n_state = (in_key == '0 || role_full) ? S_RESP : S_TOPIC;
                        end
                        ACT_REMOVE, ACT_LIST_TOPIC: begin
                            n_state = (in_key == '0) ? S_RESP : S_TOPIC;
                        end
                        ACT_LIST_PUB, ACT_LIST_SUB: begin
                            n_state = S_LIST;
                        end
                        default: begin
                            n_state = S_RESP;
                        end
                    endcase
                end
            end
            S_TOPIC: begin
                if (step) begin
                    if (r_action == ACT_ADD) begin
                        if (name_free || key_hit) begin
                            n_state = S_SLOT;
                        end else if (at_end) begin
                            n_state = S_RESP;
                        end
                    end else if (key_hit) begin
                        n_state = (r_action == ACT_REMOVE) ? S_SLOT : S_LIST;
                    end else if (at_end) begin
                        n_state = S_RESP;
                    end
                end
            end
            S_SLOT: begin
                if (step) begin
                    if (r_action == ACT_ADD) begin
                        if (!entry.valid || at_end) begin
                            n_state = S_RESP;
                        end
                    end else if (id_hit) begin
                        n_state = S_EMPTY;
                    end else if (at_end) begin
                        n_state = S_RESP;
                    end
                end
            end
            S_EMPTY: begin
                if (step && (entry.valid || (at_end && r_role))) begin
                    n_state = S_RESP;
                end
            end
            S_LIST: begin
                if (step && at_end && !(entry.valid && r_have && !i_free)) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (i_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_idx       = r_idx;
        n_wait      = 1'b0;
        n_lim       = r_lim;
        n_lin       = r_lin;
        n_role      = r_role;
        n_topic     = r_topic;
        n_action    = r_action;
        n_key       = r_key;
        n_conn      = r_conn;
        n_cid       = r_cid;
        n_status    = r_status;
        n_id        = r_id;
        n_have      = r_have;
        n_pend      = r_pend;
        n_pub_total = r_pub_total;
        n_sub_total = r_sub_total;
        n_next_id   = r_next_id;
        topic_we    = 1'b0;
        topic_wd    = '0;
        pub_we      = 1'b0;
        sub_we      = 1'b0;
        slot_wd     = '0;
        o_push      = 1'b0;
        o_res       = '0;
        o_res.last  = 1'b1;

        unique case (r_state)
            S_CLEAR: begin
                topic_we = (int'(r_idx) < TOPIC_SLOTS);
                pub_we   = (int'(r_idx) < TOPIC_SLOTS * PUB_SLOTS);
                sub_we   = (int'(r_idx) < TOPIC_SLOTS * SUB_SLOTS);
                n_idx    = (r_idx == CLR_LAST) ? '0 : r_idx + IW'(1);
            end
            S_IDLE: begin
                if (accept) begin
                    n_action = i_action;
                    n_role   = i_role;
                    n_key    = in_key;
                    n_conn   = i_connection;
                    n_cid    = i_client_id;
                    n_have   = 1'b0;
                    n_id     = '0;
                    n_idx    = '0;
                    n_wait   = 1'b1;
                    n_lin    = 1'b0;
                    n_lim    = TOP_LAST;
                    n_status = STAT_MISS;
                    unique case (i_action)
                        ACT_ADD: begin
                            if (in_key != '0) begin
                                n_status = STAT_FULL;
                            end
                        end
                        ACT_LIST_TOPIC: begin
                            n_role = 1'b1;
                        end
                        ACT_LIST_PUB, ACT_LIST_SUB: begin
                            n_role   = (i_action == ACT_LIST_SUB);
                            n_lin    = 1'b1;
                            n_lim    = (i_action == ACT_LIST_SUB) ? SUB_ALL_LAST
                                                                  : PUB_ALL_LAST;
                            n_status = STAT_OK;
                        end
                        default: begin
                            n_status = STAT_MISS;
                        end
                    endcase
                end
            end
            S_TOPIC: begin
                if (step) begin
                    if ((r_action == ACT_ADD) ? (name_free || key_hit) : key_hit) begin
                        n_topic = r_idx[TAW-1:0];
                        n_idx   = '0;
                        n_wait  = 1'b1;
                        n_lim   = r_role ? S_LAST : P_LAST;
                        if (r_action == ACT_LIST_TOPIC) begin
                            n_status = STAT_OK;
                        end
                    end else if (!at_end) begin
                        n_idx  = r_idx + IW'(1);
                        n_wait = 1'b1;
                    end
                end
            end
            S_SLOT: begin
                if (step) begin
                    if (r_action == ACT_ADD && !entry.valid) begin
                        slot_wd  = '{valid: 1'b1, id: r_next_id, conn: r_conn};
                        pub_we   = !r_role;
                        sub_we   = r_role;
                        topic_we = 1'b1;
                        topic_wd = r_key;
                        n_id      = r_next_id;
                        n_next_id = r_next_id + ID_W'(1);
                        n_status  = STAT_OK;
                        if (r_role) begin
                            n_sub_total = r_sub_total + CSW'(1);
                        end else begin
                            n_pub_total = r_pub_total + CPW'(1);
                        end
                    end else if (r_action != ACT_ADD && id_hit) begin
                        pub_we   = !r_role;
                        sub_we   = r_role;
                        n_status = STAT_OK;
                        if (r_role) begin
                            if (r_sub_total != '0) begin
                                n_sub_total = r_sub_total - CSW'(1);
                            end
                        end else if (r_pub_total != '0) begin
                            n_pub_total = r_pub_total - CPW'(1);
                        end
                        // Now look for any client left in this topic.
                        n_role = 1'b0;
                        n_idx  = '0;
                        n_wait = 1'b1;
                        n_lim  = P_LAST;
                    end else if (!at_end) begin
                        n_idx  = r_idx + IW'(1);
                        n_wait = 1'b1;
                    end
                end
            end
            S_EMPTY: begin
                if (step && !entry.valid) begin
                    if (!at_end) begin
                        n_idx  = r_idx + IW'(1);
                        n_wait = 1'b1;
                    end else if (!r_role) begin
                        n_role = 1'b1;
                        n_idx  = '0;
                        n_wait = 1'b1;
                        n_lim  = S_LAST;
                    end else begin
                        topic_we = 1'b1;
                    end
                end
            end
            S_LIST: begin
                // One handle is held back so that the final one can carry last.
                if (step && !(entry.valid && r_have && !i_free)) begin
                    if (entry.valid) begin
                        if (r_have) begin
                            o_push           = 1'b1;
                            o_res.status     = STAT_OK;
                            o_res.item_valid = 1'b1;
                            o_res.conn       = r_pend;
                            o_res.last       = 1'b0;
                        end
                        n_have = 1'b1;
                        n_pend = entry.conn;
                    end
                    if (!at_end) begin
                        n_idx  = r_idx + IW'(1);
                        n_wait = 1'b1;
                    end
                end
            end
            S_RESP: begin
                o_push            = 1'b1;
                o_res.status      = r_status;
                o_res.assigned_id = r_id;
                o_res.item_valid  = r_have;
                o_res.conn        = r_have ? r_pend : '0;
            end
            default: begin
                n_wait = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_wait      <= 1'b0;
            r_lin       <= 1'b1;
            r_have      <= 1'b0;
            r_pub_total <= '0;
            r_sub_total <= '0;
            r_next_id   <= '0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_wait      <= n_wait;
            r_lin       <= n_lin;
            r_have      <= n_have;
            r_pub_total <= n_pub_total;
            r_sub_total <= n_sub_total;
            r_next_id   <= n_next_id;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lim    <= n_lim;
        r_role   <= n_role;
        r_topic  <= n_topic;
        r_action <= n_action;
        r_key    <= n_key;
        r_conn   <= n_conn;
        r_cid    <= n_cid;
        r_status <= n_status;
        r_id     <= n_id;
        r_pend   <= n_pend;
    end

endmodule

`default_nettype wire

/* hw/rtl/pmt_out_buf.sv */
`default_nettype none

module pmt_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  pmt_pkg::t_result i_res,
    output logic             o_free,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output pmt_pkg::t_result o_res
);
    import pmt_pkg::*;

    logic    r_valid;
    t_result r_res;

    // The slot frees up in the same cycle that its beat is taken.
    assign o_free      = !r_valid || !i_out_stall;
    assign o_out_valid = r_valid;
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_push) begin
            r_res <= i_res;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/pubsub_membership_table_top.sv */
// Topic membership table for a publish/subscribe broker.
// Input channel: i_in_valid / o_in_stall carry one command beat (add, remove,
// list one topic's subscribers, list all publishers, list all subscribers).
// Output channel: o_out_valid / i_out_stall carry result beats. Add, remove
// and unknown commands give one beat; lists give one beat per handle, the
// final one flagged by o_last, or a single empty beat.
// One command is in work at a time; o_in_stall is high until its last beat is
// handed to the output register. Every table lookup is a registered memory
// read, and the sequencer waits for the read data of each entry it visits.
// A remove scans the topics, the slots of its role and then both roles'
// slots to see if the topic is empty; a full list walks every slot of its role.
// After reset a clearing pass over TOPIC_SLOTS * max(PUB_SLOTS, SUB_SLOTS)
// table addresses (64 at the defaults) empties the tables; input stays stalled.
// A stalled output beat holds in the output register and the sequencer
// waits for it to drain before producing the next one.
`default_nettype none

module pubsub_membership_table_top #(
    parameter int TOPIC_SLOTS = pmt_pkg::TOPIC_SLOTS_DEF,
    parameter int PUB_SLOTS   = pmt_pkg::PUB_SLOTS_DEF,
    parameter int SUB_SLOTS   = pmt_pkg::SUB_SLOTS_DEF,
    parameter int NAME_BYTES  = pmt_pkg::NAME_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [pmt_pkg::ACTION_W-1:0]  i_action,
    input  logic                          i_role,
    input  logic [pmt_pkg::KEY_W-1:0]     i_topic_key,
    input  logic [pmt_pkg::CONN_W-1:0]    i_connection,
    input  logic [pmt_pkg::ID_W-1:0]      i_client_id,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [pmt_pkg::STATUS_W-1:0]  o_status,
    output logic [pmt_pkg::ID_W-1:0]      o_assigned_id,
    output logic                          o_item_valid,
    output logic [pmt_pkg::CONN_W-1:0]    o_connection_out,
    output logic                          o_last
);
    import pmt_pkg::*;

    logic    push;
    logic    free;
    t_result core_res;
    t_result out_res;

    pmt_core #(
        .TOPIC_SLOTS (TOPIC_SLOTS),
        .PUB_SLOTS   (PUB_SLOTS),
        .SUB_SLOTS   (SUB_SLOTS),
        .NAME_BYTES  (NAME_BYTES)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_action     (i_action),
        .i_role       (i_role),
        .i_topic_key  (i_topic_key),
        .i_connection (i_connection),
        .i_client_id  (i_client_id),
        .o_push       (push),
        .o_res        (core_res),
        .i_free       (free)
    );

    pmt_out_buf u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_res       (core_res),
        .o_free      (free),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_res       (out_res)
    );

    assign o_status         = out_res.status;
    assign o_assigned_id    = out_res.assigned_id;
    assign o_item_valid     = out_res.item_valid;
    assign o_connection_out = out_res.conn;
    assign o_last           = out_res.last;

endmodule

`default_nettype wire

/* hw/rtl/pmt_checker.sv */
`default_nettype none
`include "pubsub_membership_table_top_assert.svh"

module pmt_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          o_in_stall,
    input wire logic                          o_out_valid,
    input wire logic                          i_out_stall,
    input wire logic [pmt_pkg::STATUS_W-1:0]  o_status,
    input wire logic [pmt_pkg::ID_W-1:0]      o_assigned_id,
    input wire logic                          o_item_valid,
    input wire logic [pmt_pkg::CONN_W-1:0]    o_connection_out,
    input wire logic                          o_last
);
    import pmt_pkg::*;

    `PMT_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_connection_out) && $stable(o_last), "stalled output beat changed")
    `PMT_ASSERT_NXT(a_one_cmd, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "second command taken while one is in work")
    `PMT_ASSERT_IMP(a_item_ok, i_clk, i_rst_n, o_out_valid && o_item_valid, o_status == STAT_OK && o_assigned_id == '0, "listed handle with bad status or id")
    `PMT_ASSERT_IMP(a_more_is_item, i_clk, i_rst_n, o_out_valid && !o_last, o_item_valid, "non-final beat carries no handle")

endmodule

bind pubsub_membership_table_top pmt_checker u_pmt_checker (.*);

`default_nettype wire

/* test/tb_pubsub_membership_table_top.sv */
`timescale 1ns / 100ps

module tb_pubsub_membership_table_top;

    import pmt_pkg::*;

    localparam int NT = 8;
    localparam int NP = 8;
    localparam int NS = 8;
    localparam int NB = 8;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic [ACTION_W-1:0] i_action = ACT_ADD;
    logic                i_role = 1'b0;
    logic [KEY_W-1:0]    i_topic_key = '0;
    logic [CONN_W-1:0]   i_connection = '0;
    logic [ID_W-1:0]     i_client_id = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [STATUS_W-1:0] o_status;
    logic [ID_W-1:0]     o_assigned_id;
    logic                o_item_valid;
    logic [CONN_W-1:0]   o_connection_out;
    logic                o_last;

    pubsub_membership_table_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_action         (i_action),
        .i_role           (i_role),
        .i_topic_key      (i_topic_key),
        .i_connection     (i_connection),
        .i_client_id      (i_client_id),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_assigned_id    (o_assigned_id),
        .o_item_valid     (o_item_valid),
        .o_connection_out (o_connection_out),
        .o_last           (o_last)
    );

    always #1 i_clk = ~i_clk;

    // Shadow copy of the membership table.
    logic [KEY_W-1:0]  topic_tbl [NT];
    bit                pub_on [NT*NP];
    logic [ID_W-1:0]   pub_id [NT*NP];
    logic [CONN_W-1:0] pub_conn [NT*NP];
    bit                sub_on [NT*NS];
    logic [ID_W-1:0]   sub_id [NT*NS];
    logic [CONN_W-1:0] sub_conn [NT*NS];
    int                pub_count;
    int                sub_count;
    logic [ID_W-1:0]   id_next;

    t_result expected_beats [$];
    int      err_count;
    int      items_sent;
    int      beats_seen;
    int      burst_left;

    function automatic logic [KEY_W-1:0] trim_key(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] r;
        bit               stop;
        r    = '0;
        stop = 0;
        for (int b = 0; b < NB; b++) begin
            if (!stop) begin
                if (k[8*b +: 8] == 8'd0) stop = 1;
                else r[8*b +: 8] = k[8*b +: 8];
            end
        end
        return r;
    endfunction

    function automatic void push_beat(input logic [STATUS_W-1:0] st, input logic [ID_W-1:0] id,
                                      input logic iv, input logic [CONN_W-1:0] cn,
                                      input logic lst);
        t_result r;
        r.status      = st;
        r.assigned_id = id;
        r.item_valid  = iv;
        r.conn        = cn;
        r.last        = lst;
        expected_beats.push_back(r);
    endfunction

    function automatic int lookup_topic(input logic [KEY_W-1:0] key);
        if (key == '0) return -1;
        for (int t = 0; t < NT; t++)
            if (topic_tbl[t] == key) return t;
        return -1;
    endfunction

    function automatic logic [STATUS_W-1:0] apply_add(input bit sub, input logic [KEY_W-1:0] key,
                                                      input logic [CONN_W-1:0] cn,
                                                      output logic [ID_W-1:0] id);
        int t;
        int j;
        id = '0;
        if (key == '0) return STAT_MISS;
        if ((sub ? sub_count : pub_count) >= (sub ? NS : NP)) return STAT_FULL;
        for (t = 0; t < NT; t++)
            if (topic_tbl[t] == '0 || topic_tbl[t] == key) break;
        if (t == NT) return STAT_FULL;
        for (j = 0; j < (sub ? NS : NP); j++)
            if (!(sub ? sub_on[t*NS+j] : pub_on[t*NP+j])) break;
        if (j == (sub ? NS : NP)) return STAT_FULL;
        topic_tbl[t] = key;
        id = id_next;
        if (sub) begin
            sub_on[t*NS+j]   = 1;
            sub_id[t*NS+j]   = id_next;
            sub_conn[t*NS+j] = cn;
            sub_count++;
        end else begin
            pub_on[t*NP+j]   = 1;
            pub_id[t*NP+j]   = id_next;
            pub_conn[t*NP+j] = cn;
            pub_count++;
        end
        id_next = id_next + 1;
        return STAT_OK;
    endfunction

    function automatic logic [STATUS_W-1:0] apply_remove(input bit sub,
                                                         input logic [KEY_W-1:0] key,
                                                         input logic [ID_W-1:0] cid);
        int  t;
        int  j;
        bit  busy;
        t = lookup_topic(key);
        if (t < 0) return STAT_MISS;
        for (j = 0; j < (sub ? NS : NP); j++) begin
            if (sub && sub_on[t*NS+j] && sub_id[t*NS+j] == cid) break;
            if (!sub && pub_on[t*NP+j] && pub_id[t*NP+j] == cid) break;
        end
        if (j == (sub ? NS : NP)) return STAT_MISS;
        if (sub) begin
            sub_on[t*NS+j] = 0;
            if (sub_count > 0) sub_count--;
        end else begin
            pub_on[t*NP+j] = 0;
            if (pub_count > 0) pub_count--;
        end
        busy = 0;
        for (int k = 0; k < NP; k++) busy |= pub_on[t*NP+k];
        for (int k = 0; k < NS; k++) busy |= sub_on[t*NS+k];
        if (!busy) topic_tbl[t] = '0;
        return STAT_OK;
    endfunction

    // Computes the result beats of one accepted command and updates the shadow table.
    function automatic void predict_beats(input logic [ACTION_W-1:0] act, input bit sub,
                                          input logic [KEY_W-1:0] raw_key,
                                          input logic [CONN_W-1:0] cn,
                                          input logic [ID_W-1:0] cid);
        logic [KEY_W-1:0]    key;
        logic [STATUS_W-1:0] st;
        logic [ID_W-1:0]     id;
        int                  t;
        int                  n;
        key = trim_key(raw_key);
        n   = 0;
        if (act == ACT_ADD) begin
            st = apply_add(sub, key, cn, id);
            push_beat(st, (st == STAT_OK) ? id : '0, 0, '0, 1);
        end else if (act == ACT_REMOVE) begin
            push_beat(apply_remove(sub, key, cid), '0, 0, '0, 1);
        end else if (act == ACT_LIST_TOPIC || act == ACT_LIST_PUB || act == ACT_LIST_SUB) begin
            if (act == ACT_LIST_TOPIC) begin
                t = lookup_topic(key);
                if (t < 0) begin
                    push_beat(STAT_MISS, '0, 0, '0, 1);
                    return;
                end
                for (int j = 0; j < NS; j++)
                    if (sub_on[t*NS+j]) begin
                        push_beat(STAT_OK, '0, 1, sub_conn[t*NS+j], 0);
                        n++;
                    end
            end else begin
                for (int tt = 0; tt < NT; tt++) begin
                    if (topic_tbl[tt] != '0) begin
                        for (int j = 0; j < NS; j++) begin
                            if (act == ACT_LIST_SUB && sub_on[tt*NS+j]) begin
                                push_beat(STAT_OK, '0, 1, sub_conn[tt*NS+j], 0);
                                n++;
                            end else if (act == ACT_LIST_PUB && pub_on[tt*NP+j]) begin
                                push_beat(STAT_OK, '0, 1, pub_conn[tt*NP+j], 0);
                                n++;
                            end
                        end
                    end
                end
            end
            if (n == 0) push_beat(STAT_OK, '0, 0, '0, 1);
            else expected_beats[$].last = 1;
        end else begin
            push_beat(STAT_MISS, '0, 0, '0, 1);
        end
    endfunction

    // Drives one command beat, waits for it to be taken, then maybe pauses.
    task automatic send_cmd(input logic [ACTION_W-1:0] act, input bit sub,
                            input logic [KEY_W-1:0] key, input logic [CONN_W-1:0] cn,
                            input logic [ID_W-1:0] cid);
        int gap;
        @(negedge i_clk);
        i_in_valid   = 1'b1;
        i_action     = act;
        i_role       = sub;
        i_topic_key  = key;
        i_connection = cn;
        i_client_id  = cid;
        do @(posedge i_clk); while (o_in_stall);
        predict_beats(act, sub, key, cn, cid);
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 8);
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            burst_left = $urandom_range(0, 12);
        end
    endtask

    // The receiver alternates between free-running, light and heavy stalling.
    int stall_mode;
    int stall_left;
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(5, 60);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            0: i_out_stall = 1'b0;
            1: i_out_stall = ($urandom_range(0, 3) == 0);
            default: i_out_stall = ($urandom_range(0, 3) != 0);
        endcase
    end

    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            beats_seen++;
            if (expected_beats.size() == 0) begin
                $error("result beat with nothing expected");
                err_count++;
            end else begin
                e = expected_beats.pop_front();
                if (o_status !== e.status) begin
                    $error("status: expected %0d, got %0d", e.status, o_status);
                    err_count++;
                end
                if (o_assigned_id !== e.assigned_id) begin
                    $error("assigned_id: expected %0d, got %0d", e.assigned_id, o_assigned_id);
                    err_count++;
                end
                if (o_item_valid !== e.item_valid) begin
                    $error("item_valid: expected %0d, got %0d", e.item_valid, o_item_valid);
                    err_count++;
                end
                if (o_connection_out !== e.conn) begin
                    $error("connection_out: expected %h, got %h", e.conn, o_connection_out);
                    err_count++;
                end
                if (o_last !== e.last) begin
                    $error("last: expected %0d, got %0d", e.last, o_last);
                    err_count++;
                end
            end
        end
    end

    function automatic logic [KEY_W-1:0] pool_key(input int i);
        case (i)
            0: return 64'hFFFF_FFFF_FFFF_FFFF;
            1: return 64'h0000_0000_0000_4142;
            2: return 64'hDEAD_BEEF_0000_4142;
            3: return 64'h0000_0000_0000_0031;
            4: return 64'h8000_0000_0000_0001;
            5: return 64'h7F7F_7F7F_7F7F_7F7F;
            6: return 64'h0102_0304_0506_0708;
            7: return 64'h0000_0000_0063_6261;
            8: return 64'h5555_AAAA_5555_AAAA;
            9: return 64'h00FF_FF00_FF00_FF01;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic test_empty_and_bad_keys();
        send_cmd(ACT_LIST_PUB, 0, '0, '0, '0);
        send_cmd(ACT_LIST_SUB, 1, '0, '0, '0);
        send_cmd(ACT_LIST_TOPIC, 1, 64'h0, '0, '0);
        send_cmd(ACT_ADD, 0, 64'h0, 16'h1234, '0);
        send_cmd(ACT_ADD, 1, 64'hFFFF_FFFF_FFFF_FF00, 16'h1234, '0);
        send_cmd(ACT_REMOVE, 0, 64'h0, '0, '0);
        send_cmd(ACT_REMOVE, 1, pool_key(3), '0, 32'hFFFF_FFFF);
    endtask

    task automatic test_fill_and_overflow();
        for (int i = 0; i < 8; i++)
            send_cmd(ACT_ADD, 1, pool_key(i == 2 ? 8 : i), i[0] ? 16'hFFFF : 16'(i), '0);
        send_cmd(ACT_ADD, 1, pool_key(9), 16'h5A5A, '0);
        send_cmd(ACT_ADD, 0, pool_key(9), 16'hA5A5, '0);
        send_cmd(ACT_ADD, 0, pool_key(2), 16'hFFFF, 32'hFFFF_FFFF);
        send_cmd(ACT_LIST_SUB, 0, '0, '0, '0);
        send_cmd(ACT_LIST_PUB, 0, '0, '0, '0);
        send_cmd(ACT_LIST_TOPIC, 0, pool_key(2), '0, '0);
        send_cmd(ACT_REMOVE, 1, pool_key(0), '0, 32'd99);
        send_cmd(ACT_REMOVE, 0, pool_key(1), '0, 32'd9);
        send_cmd(ACT_REMOVE, 1, pool_key(1), '0, 32'd1);
        send_cmd(ACT_LIST_TOPIC, 1, pool_key(1), '0, '0);
    endtask

    task automatic test_unknown_actions();
        send_cmd(3'd5, 0, pool_key(0), 16'hFFFF, 32'hFFFF_FFFF);
        send_cmd(3'd6, 1, pool_key(1), '0, '0);
        send_cmd(3'd7, 1, pool_key(4), '0, '0);
    endtask

    task automatic test_random_traffic(input int count);
        int          pick;
        int          t;
        int          j;
        bit          sub;
        logic [KEY_W-1:0] key;
        logic [ID_W-1:0]  cid;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            sub  = 1'($urandom_range(0, 1));
            key  = pool_key($urandom_range(0, 11));
            cid  = $urandom;
            if (pick < 45) begin
                send_cmd(ACT_ADD, sub, key, 16'($urandom), $urandom);
            end else if (pick < 75) begin
                // Mostly remove a real member so the table keeps churning.
                if ($urandom_range(0, 4) != 0) begin
                    t = $urandom_range(0, NT - 1);
                    j = $urandom_range(0, NS - 1);
                    for (int k = 0; k < NT * NS; k++) begin
                        if (topic_tbl[(t + k / NS) % NT] != '0 &&
                            (sub ? sub_on[((t + k / NS) % NT) * NS + (j + k) % NS]
                                 : pub_on[((t + k / NS) % NT) * NP + (j + k) % NP])) begin
                            key = topic_tbl[(t + k / NS) % NT];
                            cid = sub ? sub_id[((t + k / NS) % NT) * NS + (j + k) % NS]
                                      : pub_id[((t + k / NS) % NT) * NP + (j + k) % NP];
                            break;
                        end
                    end
                end
                send_cmd(ACT_REMOVE, sub, key, 16'($urandom), cid);
            end else if (pick < 87) begin
                send_cmd(ACT_LIST_TOPIC, sub, key, 16'($urandom), cid);
            end else if (pick < 92) begin
                send_cmd(ACT_LIST_PUB, sub, key, 16'($urandom), cid);
            end else if (pick < 97) begin
                send_cmd(ACT_LIST_SUB, sub, key, 16'($urandom), cid);
            end else begin
                send_cmd(3'($urandom_range(5, 7)), sub, key, 16'($urandom), cid);
            end
        end
    endtask

    initial begin
        int waited;
        for (int i = 0; i < NT; i++) topic_tbl[i] = '0;
        for (int i = 0; i < NT * NS; i++) begin
            pub_on[i] = 0;
            sub_on[i] = 0;
        end
        pub_count  = 0;
        sub_count  = 0;
        id_next    = '0;
        err_count  = 0;
        items_sent = 0;
        beats_seen = 0;
        burst_left = 0;
        stall_left = 0;
        stall_mode = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_and_bad_keys();
        test_fill_and_overflow();
        test_unknown_actions();
        test_random_traffic(342);

        @(negedge i_clk);
        i_in_valid = 1'b0;
        waited = 0;
        while (expected_beats.size() != 0 && waited < 200000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (200) @(posedge i_clk);
        if (expected_beats.size() != 0) begin
            $error("%0d result beats never arrived", expected_beats.size());
            err_count++;
        end
        $display("Sent %0d commands (adds, removes, lists, unknown actions), checked %0d beats.",
                 items_sent, beats_seen);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
